/* src/skvt_pkg.sv */
`timescale 1ns / 1ps
// skvt_pkg: operation codes and sequencer states for the sorted key/value table
// no dependencies

package skvt_pkg;

	typedef enum logic [1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_LOOKUP = 2'd2,
		FUNC_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD_RD,
		ST_ADD_CMP,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_RM_RD,
		ST_RM_WR
	} state_t;

endpackage

/* src/sorted_key_value_table_top.sv */
`timescale 1ns / 1ps
// sorted_key_value_table_top: sorted key/value table on one entry memory with one write and one read port
// depends on skvt_pkg
// clear, and an add to a full table, finish straight from idle; an add walks down from the top
// end, moving each larger entry up one slot; lookup and remove run a binary search, and a remove
// hit then moves each later entry down one slot; each probe or move is a read state then a compare or write state
// busy is low while done is high, so the next request can be taken then; no receiver stall
// reset clears the entry count and the sequencer; stored entries are not cleared

module sorted_key_value_table_top #(
	parameter int CAPACITY   = 64,
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       func,
	input  logic [KEY_BITS-1:0]              key,
	input  logic [VALUE_BITS-1:0]            item_value,
	output logic                             done,
	output logic                             ok,
	output logic [VALUE_BITS-1:0]            found_value,
	output logic [$clog2(CAPACITY+1)-1:0]    entry_count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = KEY_BITS + VALUE_BITS;

	logic [EW-1:0] mem [CAPACITY];
	logic [EW-1:0] rd_q;

	skvt_pkg::state_t state_q, state_d;
	logic [CW-1:0]         count_q, count_d;
	logic                  done_q, done_d;
	skvt_pkg::func_t       func_q, func_d;
	logic [KEY_BITS-1:0]   key_q, key_d;
	logic [VALUE_BITS-1:0] val_q, val_d;
	logic [CW-1:0]         i_q, i_d;
	logic [CW-1:0]         lo_q, lo_d;
	logic [CW-1:0]         hi_q, hi_d;
	logic                  ok_q, ok_d;
	logic [VALUE_BITS-1:0] fv_q, fv_d;

	logic [AW-1:0] ra_c, wa_c;
	logic [EW-1:0] wd_c;
	logic          we_c;
	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid_c;
	logic [CW-1:0] next_i;
	logic [KEY_BITS-1:0] rkey;

	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - {{CW{1'b0}}, 1'b1};
	assign mid_c   = mid_sum[CW:1];
	assign next_i  = i_q + {{(CW-1){1'b0}}, 1'b1};
	assign rkey    = rd_q[EW-1:VALUE_BITS];

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		done_d  = 1'b0;
		func_d  = func_q;
		key_d   = key_q;
		val_d   = val_q;
		i_d     = i_q;
		lo_d    = lo_q;
		hi_d    = hi_q;
		ok_d    = ok_q;
		fv_d    = fv_q;
		ra_c    = '0;
		wa_c    = '0;
		wd_c    = rd_q;
		we_c    = 1'b0;
		case (state_q)
			skvt_pkg::ST_IDLE: begin
				if (start) begin
					func_d = skvt_pkg::func_t'(func);
					key_d  = key;
					val_d  = item_value;
					ok_d   = 1'b0;
					fv_d   = '0;
					lo_d   = '0;
					hi_d   = count_q;
					i_d    = count_q;
					case (skvt_pkg::func_t'(func))
						skvt_pkg::FUNC_ADD: begin
							if (count_q == CW'(CAPACITY)) begin
								done_d = 1'b1;
							end else begin
								state_d = skvt_pkg::ST_ADD_RD;
							end
						end
						skvt_pkg::FUNC_CLEAR: begin
							count_d = '0;
							ok_d    = 1'b1;
							done_d  = 1'b1;
						end
						default: begin
							state_d = skvt_pkg::ST_SRCH_RD;
						end
					endcase
				end
			end
			skvt_pkg::ST_ADD_RD: begin
				if (i_q == '0) begin
					we_c    = 1'b1;
					wa_c    = '0;
					wd_c    = {key_q, val_q};
					count_d = count_q + {{(CW-1){1'b0}}, 1'b1};
					ok_d    = 1'b1;
					done_d  = 1'b1;
					state_d = skvt_pkg::ST_IDLE;
				end else begin
					ra_c    = AW'(i_q - {{(CW-1){1'b0}}, 1'b1});
					state_d = skvt_pkg::ST_ADD_CMP;
				end
			end
			skvt_pkg::ST_ADD_CMP: begin
				we_c = 1'b1;
				wa_c = i_q[AW-1:0];
				if (key_q < rkey) begin
					wd_c    = rd_q;
					i_d     = i_q - {{(CW-1){1'b0}}, 1'b1};
					state_d = skvt_pkg::ST_ADD_RD;
				end else begin
					wd_c    = {key_q, val_q};
					count_d = count_q + {{(CW-1){1'b0}}, 1'b1};
					ok_d    = 1'b1;
					done_d  = 1'b1;
					state_d = skvt_pkg::ST_IDLE;
				end
			end
			skvt_pkg::ST_SRCH_RD: begin
				if (lo_q >= hi_q) begin
					done_d  = 1'b1;
					state_d = skvt_pkg::ST_IDLE;
				end else begin
					ra_c    = mid_c[AW-1:0];
					i_d     = mid_c;
					state_d = skvt_pkg::ST_SRCH_CMP;
				end
			end
			skvt_pkg::ST_SRCH_CMP: begin
				if (key_q == rkey) begin
					ok_d = 1'b1;
					if (func_q == skvt_pkg::FUNC_LOOKUP) begin
						fv_d    = rd_q[VALUE_BITS-1:0];
						done_d  = 1'b1;
						state_d = skvt_pkg::ST_IDLE;
					end else begin
						state_d = skvt_pkg::ST_RM_RD;
					end
				end else if (key_q < rkey) begin
					hi_d    = i_q;
					state_d = skvt_pkg::ST_SRCH_RD;
				end else begin
					lo_d    = next_i;
					state_d = skvt_pkg::ST_SRCH_RD;
				end
			end
			skvt_pkg::ST_RM_RD: begin
				if (next_i < count_q) begin
					ra_c    = next_i[AW-1:0];
					state_d = skvt_pkg::ST_RM_WR;
				end else begin
					count_d = count_q - {{(CW-1){1'b0}}, 1'b1};
					done_d  = 1'b1;
					state_d = skvt_pkg::ST_IDLE;
				end
			end
			skvt_pkg::ST_RM_WR: begin
				we_c    = 1'b1;
				wa_c    = i_q[AW-1:0];
				wd_c    = rd_q;
				i_d     = next_i;
				state_d = skvt_pkg::ST_RM_RD;
			end
			default: begin
				state_d = skvt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skvt_pkg::ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		func_q <= func_d;
		key_q  <= key_d;
		val_q  <= val_d;
		i_q    <= i_d;
		lo_q   <= lo_d;
		hi_q   <= hi_d;
		ok_q   <= ok_d;
		fv_q   <= fv_d;
	end

	// entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[wa_c] <= wd_c;
		end
		rd_q <= mem[ra_c];
	end

	assign busy        = (state_q != skvt_pkg::ST_IDLE);
	assign done        = done_q;
	assign ok          = ok_q;
	assign found_value = fv_q;
	assign entry_count = count_q;

endmodule

/* verif/sorted_key_value_table_top_test.sv */
`timescale 1ns / 1ps
// sorted_key_value_table_top_test: self-checking testbench for the sorted key/value table
// depends on skvt_pkg and sorted_key_value_table_top; a class predicts every response

module sorted_key_value_table_top_test;

	localparam int CAPACITY     = 64;
	localparam int RANDOM_ITEMS = 400;
	localparam int CALM_ITEMS   = 60;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic        ok;
		logic [31:0] found_value;
		logic [6:0]  entry_count;
	} response_t;

	class sorted_table_model;
		logic [31:0] keys [CAPACITY];
		logic [31:0] values [CAPACITY];
		int count;
		int errors;
		response_t pending_results [$];

		function new();
			count = 0;
			errors = 0;
		endfunction

		// binary search over the used entries, midpoint rounded down
		function bit find_slot(logic [31:0] k, output int slot);
			int lo;
			int hi;
			int mid;
			lo = 0;
			hi = count - 1;
			slot = 0;
			while (lo <= hi) begin
				mid = lo + (hi - lo) / 2;
				if (k == keys[mid]) begin
					slot = mid;
					return 1;
				end
				if (k < keys[mid])
					hi = mid - 1;
				else
					lo = mid + 1;
			end
			return 0;
		endfunction

		function void note_request(skvt_pkg::func_t f, logic [31:0] k, logic [31:0] v);
			response_t r;
			int slot;
			int i;
			r = '0;
			case (f)
			skvt_pkg::FUNC_ADD: begin
				if (count < CAPACITY) begin
					i = count;
					while (i > 0 && k < keys[i-1]) begin
						keys[i] = keys[i-1];
						values[i] = values[i-1];
						i--;
					end
					keys[i] = k;
					values[i] = v;
					count++;
					r.ok = 1'b1;
				end
			end
			skvt_pkg::FUNC_REMOVE: begin
				if (find_slot(k, slot)) begin
					for (i = slot; i < count - 1; i++) begin
						keys[i] = keys[i+1];
						values[i] = values[i+1];
					end
					count--;
					r.ok = 1'b1;
				end
			end
			skvt_pkg::FUNC_LOOKUP: begin
				if (find_slot(k, slot)) begin
					r.ok = 1'b1;
					r.found_value = values[slot];
				end
			end
			default: begin
				count = 0;
				r.ok = 1'b1;
			end
			endcase
			r.entry_count = 7'(count);
			pending_results.push_back(r);
		endfunction

		function void check_response(logic ok, logic [31:0] fv, logic [6:0] cnt);
			response_t e;
			if (pending_results.size() == 0) begin
				$display("%0t: response with no request pending: %0b %h %0d",
					$time, ok, fv, cnt);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			if (ok !== e.ok) begin
				$display("%0t: ok expected %0b actual %0b", $time, e.ok, ok);
				errors++;
			end
			if (fv !== e.found_value) begin
				$display("%0t: found_value expected %h actual %h", $time, e.found_value, fv);
				errors++;
			end
			if (cnt !== e.entry_count) begin
				$display("%0t: entry_count expected %0d actual %0d", $time, e.entry_count, cnt);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  func;
	logic [31:0] key;
	logic [31:0] item_value;
	logic        done;
	logic        ok;
	logic [31:0] found_value;
	logic [6:0]  entry_count;

	sorted_table_model expected_table;
	int cycles = 0;

	sorted_key_value_table_top #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(32),
		.VALUE_BITS(32)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.key(key),
		.item_value(item_value),
		.done(done),
		.ok(ok),
		.found_value(found_value),
		.entry_count(entry_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			expected_table.check_response(ok, found_value, entry_count);
	end

	task automatic send_request(skvt_pkg::func_t f, logic [31:0] k, logic [31:0] v);
		@(negedge clk);
		start <= 1'b1;
		func <= f;
		key <= k;
		item_value <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		expected_table.note_request(f, k, v);
	endtask

	task automatic pause(int n);
		repeat (n) @(negedge clk)
			start <= 1'b0;
	endtask

	// mostly keys already held or from a small set, so searches hit and duplicates pile up
	function automatic logic [31:0] pick_key();
		case ($urandom_range(9))
		0, 1, 2, 3: begin
			if (expected_table.count > 0)
				return expected_table.keys[$urandom_range(expected_table.count - 1)];
			return $urandom_range(15);
		end
		4, 5, 6: return $urandom_range(15);
		7: return 32'hffff_fff0 + $urandom_range(15);
		default: return $urandom;
		endcase
	endfunction

	initial begin
		skvt_pkg::func_t f;
		int roll;
		expected_table = new();
		arst_n = 1'b0;
		start = 1'b0;
		func = skvt_pkg::FUNC_ADD;
		key = '0;
		item_value = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// empty table, extremes, duplicates, misses, clear
		send_request(skvt_pkg::FUNC_LOOKUP, 32'd0, $urandom);
		send_request(skvt_pkg::FUNC_REMOVE, 32'd5, $urandom);
		send_request(skvt_pkg::FUNC_CLEAR, $urandom, $urandom);
		send_request(skvt_pkg::FUNC_ADD, 32'hffff_ffff, 32'h0000_0000);
		send_request(skvt_pkg::FUNC_ADD, 32'h0000_0000, 32'hffff_ffff);
		send_request(skvt_pkg::FUNC_ADD, 32'd7, 32'h1111_1111);
		send_request(skvt_pkg::FUNC_ADD, 32'd7, 32'h2222_2222);
		send_request(skvt_pkg::FUNC_ADD, 32'd7, 32'h3333_3333);
		send_request(skvt_pkg::FUNC_ADD, 32'h8000_0000, $urandom);
		send_request(skvt_pkg::FUNC_LOOKUP, 32'd7, $urandom);
		send_request(skvt_pkg::FUNC_REMOVE, 32'd7, $urandom);
		send_request(skvt_pkg::FUNC_LOOKUP, 32'd7, $urandom);
		send_request(skvt_pkg::FUNC_LOOKUP, 32'd0, $urandom);
		send_request(skvt_pkg::FUNC_LOOKUP, 32'hffff_ffff, $urandom);
		send_request(skvt_pkg::FUNC_LOOKUP, 32'd8, $urandom);
		send_request(skvt_pkg::FUNC_REMOVE, 32'hffff_ffff, $urandom);
		send_request(skvt_pkg::FUNC_REMOVE, 32'd0, $urandom);
		send_request(skvt_pkg::FUNC_REMOVE, 32'd3, $urandom);
		send_request(skvt_pkg::FUNC_CLEAR, $urandom, $urandom);
		send_request(skvt_pkg::FUNC_LOOKUP, 32'd7, $urandom);
		send_request(skvt_pkg::FUNC_ADD, 32'd1, $urandom);
		send_request(skvt_pkg::FUNC_CLEAR, $urandom, $urandom);

		// grow past full, then churn, then drain
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			roll = $urandom_range(99);
			if (n < 150)
				f = roll < 70 ? skvt_pkg::FUNC_ADD :
					roll < 80 ? skvt_pkg::FUNC_REMOVE : skvt_pkg::FUNC_LOOKUP;
			else if (n < 300)
				f = roll < 40 ? skvt_pkg::FUNC_ADD : roll < 65 ? skvt_pkg::FUNC_REMOVE :
					roll < 98 ? skvt_pkg::FUNC_LOOKUP : skvt_pkg::FUNC_CLEAR;
			else
				f = roll < 25 ? skvt_pkg::FUNC_ADD : roll < 65 ? skvt_pkg::FUNC_REMOVE :
					roll < 99 ? skvt_pkg::FUNC_LOOKUP : skvt_pkg::FUNC_CLEAR;
			send_request(f, pick_key(), $urandom);
			if (n < RANDOM_ITEMS - CALM_ITEMS && (n / 40) % 2 == 0 && $urandom_range(3) == 0)
				pause($urandom_range(1, 9));
		end
		pause(1);

		while (expected_table.pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (expected_table.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
